FILE: rtl/mat_pkg.sv
// ----------------------------------------------------------------------------
// mat_pkg
// Shared types and constants of the minimum active timestamp tracker.
// ----------------------------------------------------------------------------
package mat_pkg;

   localparam int STAMP_W     = 64;
   localparam int TID_W       = 6;
   localparam int TCOUNT_W    = 7;
   localparam int CSR_INDEX_W = 1;

   localparam logic [STAMP_W-1:0] IDLE_STAMP = '1;

   // Item kinds.
   localparam logic KIND_RECORD = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_THREAD_COUNT     = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REFRESH_INTERVAL = 1'b1;

   localparam logic [TCOUNT_W-1:0] THREAD_COUNT_RESET = 7'd64;

   typedef struct packed {
      logic               kind;
      logic [TID_W-1:0]   slot_id;
      logic [STAMP_W-1:0] timestamp;
      logic [STAMP_W-1:0] now;
   } req_payload_type;

   typedef struct packed {
      logic [STAMP_W-1:0] min_timestamp;
      logic               order_violation;
   } rsp_payload_type;

   // Status of the minimum scan unit.
   typedef struct packed {
      logic               busy;
      logic               done;
      logic [STAMP_W-1:0] lowest;
   } scan_stat_type;

endpackage

FILE: rtl/mat_stream_if.sv
// ----------------------------------------------------------------------------
// mat_stream_if
// Valid/ready stream channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface mat_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/min_active_timestamp_tracker.sv
// ----------------------------------------------------------------------------
// min_active_timestamp_tracker
// Per-thread active timestamp store with a refreshed low watermark.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one item per transfer: a record (kind 0) stores timestamp
//   in the addressed thread slot, a query (kind 1) asks for the watermark.
//   rsp_if returns exactly one result per item, in order: the watermark after
//   the item and, for records, the order violation flag.
//   The csr port writes thread_count (index 0) and refresh_interval
//   (index 1); write it only while the block is idle.
// Sequencing:
//   A record passes through memory read, write back and output load. A query
//   without refresh goes straight to output load. A refreshing query from
//   thread 0 first scans min(thread_count, MAX_THREADS) slots: the slot
//   memory has one read port and the scan reads one slot per cycle. Items are
//   handled one at a time.
// Reset and stall:
//   After reset a clearing pass writes all slots idle, during which
//   req_if.ready stays low; csr writes are taken throughout.
//   The result register holds a result while rsp_if is stalled; the next item
//   is still taken and waits for the register before it completes.
// ----------------------------------------------------------------------------
module min_active_timestamp_tracker #(
   parameter int MAX_THREADS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   mat_stream_if.sink                       req_if,
   mat_stream_if.source                     rsp_if,
   input  logic                             csr_we,
   input  logic [mat_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mat_pkg::STAMP_W-1:0]      csr_wdata
);
   import mat_pkg::*;

   localparam int ADDR_W = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
   localparam int CNT_W  = $clog2(MAX_THREADS + 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_THREADS - 1);

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_READ  = 5'b00100,
      S_SCAN  = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  clr_addr_ff;
   logic [TCOUNT_W-1:0] thread_count_ff;
   logic [STAMP_W-1:0] refresh_interval_ff;
   logic [STAMP_W-1:0] watermark_ff;
   logic [STAMP_W-1:0] last_refresh_ff;
   logic [ADDR_W-1:0]  item_addr_ff;
   logic [STAMP_W-1:0] item_stamp_ff;
   logic [STAMP_W-1:0] item_now_ff;
   logic               viol_ff, viol_in;
   logic               rsp_valid_ff;
   rsp_payload_type    rsp_ff;

   logic               accept;
   logic               is_record;
   logic               tid_in_range;
   logic               do_refresh;
   logic [STAMP_W-1:0] elapsed;
   logic [CNT_W-1:0]   scan_count;
   logic               scan_start;
   logic               out_free;

   logic               mem_we, mem_re;
   logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
   logic [STAMP_W-1:0] mem_wdata, mem_rdata;

   logic               scan_rd_en;
   logic [ADDR_W-1:0]  scan_rd_addr;
   scan_stat_type      scan_stat;

   assign req_if.ready = (state_ff == S_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign is_record    = (req_if.payload.kind == KIND_RECORD);
   assign tid_in_range = int'(req_if.payload.slot_id) < MAX_THREADS;
   assign elapsed      = req_if.payload.now - last_refresh_ff;
   assign do_refresh   = !is_record && (req_if.payload.slot_id == '0)
                         && (elapsed > refresh_interval_ff);
   assign scan_count   = (int'(thread_count_ff) >= MAX_THREADS) ?
                         CNT_W'(MAX_THREADS) : CNT_W'(thread_count_ff);
   assign scan_start   = accept && do_refresh;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   // A record only raises a violation when it lowers a slot that is in use.
   assign viol_in = (mem_rdata != IDLE_STAMP) && (item_stamp_ff < mem_rdata);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (is_record && tid_in_range) begin
                  state_in = S_READ;
               end else if (do_refresh) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_READ: begin
            state_in = S_DONE;
         end
         S_SCAN: begin
            if (scan_stat.done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // Slot memory access: the clearing pass and record write-back share the
   // write port; record lookups and the scan share the read port.
   always_comb begin
      mem_we    = (state_ff == S_CLEAR) || (state_ff == S_READ);
      mem_waddr = (state_ff == S_CLEAR) ? clr_addr_ff : item_addr_ff;
      mem_wdata = (state_ff == S_CLEAR) ? IDLE_STAMP : item_stamp_ff;
      mem_re    = scan_rd_en || (accept && is_record);
      mem_raddr = scan_rd_en ? scan_rd_addr : ADDR_W'(req_if.payload.slot_id);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= S_CLEAR;
         clr_addr_ff         <= '0;
         rsp_valid_ff        <= 1'b0;
         thread_count_ff     <= THREAD_COUNT_RESET;
         refresh_interval_ff <= '0;
         watermark_ff        <= '0;
         last_refresh_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_THREAD_COUNT:     thread_count_ff     <= csr_wdata[TCOUNT_W-1:0];
               CSR_REFRESH_INTERVAL: refresh_interval_ff <= csr_wdata;
               default: ;
            endcase
         end
         if ((state_ff == S_SCAN) && scan_stat.done) begin
            if (scan_stat.lowest > watermark_ff) begin
               watermark_ff <= scan_stat.lowest;
            end
            last_refresh_ff <= item_now_ff;
         end
         if ((state_ff == S_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_addr_ff  <= ADDR_W'(req_if.payload.slot_id);
         item_stamp_ff <= req_if.payload.timestamp;
         item_now_ff   <= req_if.payload.now;
         viol_ff       <= 1'b0;
      end else if (state_ff == S_READ) begin
         viol_ff <= viol_in;
      end
      if ((state_ff == S_DONE) && out_free) begin
         rsp_ff.min_timestamp   <= watermark_ff;
         rsp_ff.order_violation <= viol_ff;
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

   mat_ram #(
      .WIDTH (STAMP_W),
      .DEPTH (MAX_THREADS)
   ) u_slots (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   mat_scan #(
      .ADDR_W (ADDR_W),
      .CNT_W  (CNT_W)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .start   (scan_start),
      .count   (scan_count),
      .rd_en   (scan_rd_en),
      .rd_addr (scan_rd_addr),
      .rd_data (mem_rdata),
      .stat    (scan_stat)
   );

   // The input side only opens when no scan is in flight.
   a_ready_no_scan: assert property (@(posedge clock) disable iff (reset)
      req_if.ready |-> !scan_stat.busy)
      else $error("input ready while a scan is running");

   // A record write-back always follows the transfer of that record.
   a_read_after_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> $past(accept))
      else $error("write-back state entered without a transfer");

   // The slot memory is never read and written in the same cycle.
   a_no_mem_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("slot memory read and written in the same cycle");

   // The scan only completes while the control is waiting for it.
   a_scan_done_owner: assert property (@(posedge clock) disable iff (reset)
      scan_stat.done |-> (state_ff == S_SCAN))
      else $error("scan finished outside the scan state");

   // The watermark never moves down.
   a_watermark_rises: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (watermark_ff >= $past(watermark_ff)))
      else $error("watermark decreased");
endmodule

FILE: rtl/mat_ram.sv
// ----------------------------------------------------------------------------
// mat_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mat_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

FILE: rtl/mat_scan.sv
// ----------------------------------------------------------------------------
// mat_scan
// Minimum scan unit: reads slots 0 to count-1, one per cycle, and keeps the
// running minimum.
// ----------------------------------------------------------------------------
module mat_scan #(
   parameter int ADDR_W = 6,
   parameter int CNT_W  = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [CNT_W-1:0]       count,
   output logic                   rd_en,
   output logic [ADDR_W-1:0]      rd_addr,
   input  logic [63:0]            rd_data,
   output mat_pkg::scan_stat_type stat
);
   import mat_pkg::*;

   logic               run_ff;
   logic               pend_ff;
   logic               done_ff;
   logic [CNT_W-1:0]   idx_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [STAMP_W-1:0] lowest_ff;
   logic               finish;

   assign rd_en   = run_ff && (idx_ff < cnt_ff);
   assign rd_addr = idx_ff[ADDR_W-1:0];
   // All reads issued and the last read data consumed.
   assign finish  = run_ff && !rd_en && !pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         pend_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= finish;
         pend_ff <= rd_en;
         if (start) begin
            run_ff <= 1'b1;
         end else if (finish) begin
            run_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         idx_ff    <= '0;
         cnt_ff    <= count;
         lowest_ff <= IDLE_STAMP;
      end else begin
         if (rd_en) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (pend_ff && (rd_data < lowest_ff)) begin
            lowest_ff <= rd_data;
         end
      end
   end

   assign stat.busy   = run_ff;
   assign stat.done   = done_ff;
   assign stat.lowest = lowest_ff;
endmodule

FILE: tb/sv/mat_checker.sv
// ----------------------------------------------------------------------------
// mat_checker
// Watches the request, result and csr ports of the timestamp tracker. Each
// request transfer is run through a behavioral copy of the slot store and
// watermark, and every result transfer is compared with the oldest
// prediction.
// ----------------------------------------------------------------------------
module mat_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  mat_pkg::req_payload_type        req_payload,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  mat_pkg::rsp_payload_type        rsp_payload,
   input  logic                            csr_we,
   input  logic [mat_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mat_pkg::STAMP_W-1:0]     csr_wdata,
   output int                              error_count,
   output int                              outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import mat_pkg::*;

   localparam int SLOTS = 64;

   logic [STAMP_W-1:0]  active_stamp [SLOTS];
   logic [STAMP_W-1:0]  watermark;
   logic [STAMP_W-1:0]  last_refresh;
   logic [TCOUNT_W-1:0] thread_count;
   logic [STAMP_W-1:0]  refresh_interval;
   rsp_payload_type     due_results [$];
   int                  mismatches = 0;

   // Applies one item to the shadow state and returns the result it causes.
   function automatic rsp_payload_type track_item(input req_payload_type item);
      rsp_payload_type    result;
      logic [STAMP_W-1:0] lowest;
      int                 scan_len;
      result.order_violation = 1'b0;
      if (item.kind == KIND_RECORD) begin
         if (active_stamp[item.slot_id] != IDLE_STAMP &&
             item.timestamp < active_stamp[item.slot_id]) begin
            result.order_violation = 1'b1;
         end
         active_stamp[item.slot_id] = item.timestamp;
      end else if (item.slot_id == '0 &&
                   (item.now - last_refresh) > refresh_interval) begin
         // Elapsed time wraps modulo 2^64; a count above the slots scans all.
         scan_len = (thread_count > SLOTS) ? SLOTS : int'(thread_count);
         lowest   = IDLE_STAMP;
         for (int i = 0; i < scan_len; i++) begin
            if (active_stamp[i] < lowest) begin
               lowest = active_stamp[i];
            end
         end
         if (lowest > watermark) begin
            watermark = lowest;
         end
         last_refresh = item.now;
      end
      result.min_timestamp = watermark;
      return result;
   endfunction

   always @(posedge clock) begin : monitor
      rsp_payload_type expected;
      if (reset) begin
         foreach (active_stamp[i]) begin
            active_stamp[i] = IDLE_STAMP;
         end
         watermark        = '0;
         last_refresh     = '0;
         thread_count     = THREAD_COUNT_RESET;
         refresh_interval = '0;
         due_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_THREAD_COUNT: begin
                  thread_count = csr_wdata[TCOUNT_W-1:0];
               end
               CSR_REFRESH_INTERVAL: begin
                  refresh_interval = csr_wdata;
               end
               default: begin
               end
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               $error("result transfer with nothing expected: min_timestamp %h, %s %b",
                      rsp_payload.min_timestamp, "order_violation",
                      rsp_payload.order_violation);
               mismatches++;
            end else begin
               expected = due_results.pop_front();
               if (rsp_payload.min_timestamp !== expected.min_timestamp) begin
                  $error("min_timestamp: expected %h, actual %h",
                         expected.min_timestamp, rsp_payload.min_timestamp);
                  mismatches++;
               end
               if (rsp_payload.order_violation !== expected.order_violation) begin
                  $error("order_violation: expected %b, actual %b",
                         expected.order_violation, rsp_payload.order_violation);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            due_results.push_back(track_item(req_payload));
         end
      end
      error_count <= mismatches;
      outstanding <= due_results.size();
   end

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Top of the timestamp tracker testbench. Drives a directed opening and then
// random record and query traffic through several thread count and refresh
// interval settings, with random gaps and result stalls. Checking is done by
// mat_checker; this module only makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mat_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SETTLE_CYCLES  = 20;
   localparam int RANDOM_ITEMS   = 95;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [STAMP_W-1:0]     csr_wdata;
   int                     error_count;
   int                     outstanding;
   int                     idle_cycles  = 0;
   int                     gap_chance   = 0;
   int                     stall_chance = 0;
   bit                     idling       = 1'b1;
   int                     hot_max      = 63;
   logic [STAMP_W-1:0]     wall_time    = 64'd5000;

   mat_stream_if #(.payload_type(req_payload_type)) req_if ();
   mat_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   min_active_timestamp_tracker u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   mat_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_ready   (req_if.ready),
      .req_payload (req_if.payload),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .rsp_payload (rsp_if.payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result side back-pressure: random bursts of stalls.
   initial begin : rsp_stall
      int stall_left;
      stall_left   = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
         end else if ($urandom_range(0, 99) < stall_chance) begin
            stall_left = $urandom_range(1, 8);
         end
         rsp_if.ready <= (stall_left == 0);
      end
   end

   function automatic req_payload_type item_of(input logic               kind,
                                               input logic [TID_W-1:0]   slot_id,
                                               input logic [STAMP_W-1:0] timestamp,
                                               input logic [STAMP_W-1:0] now);
      req_payload_type item;
      item.kind      = kind;
      item.slot_id   = slot_id;
      item.timestamp = timestamp;
      item.now       = now;
      return item;
   endfunction

   // Mostly well-formed traffic: per-thread stamps that track a rising clock,
   // thread 0 queries that refresh, plus lowered stamps and odd query times.
   function automatic req_payload_type next_random_item(input bit wide_values);
      req_payload_type item;
      int              pick;
      pick           = $urandom_range(0, 99);
      wall_time      = wall_time + 64'($urandom_range(1, 40));
      item.kind      = KIND_RECORD;
      item.slot_id   = ($urandom_range(0, 3) == 0) ? TID_W'($urandom_range(0, 63))
                                                   : TID_W'($urandom_range(0, hot_max));
      item.timestamp = wall_time - 64'($urandom_range(0, 60));
      item.now       = wall_time;
      if (pick < 15) begin
         item.timestamp = IDLE_STAMP;
      end else if (pick < 22) begin
         item.timestamp = wall_time - 64'($urandom_range(0, 4000));
      end else if (pick >= 62) begin
         item.kind      = KIND_QUERY;
         item.timestamp = {$urandom, $urandom};
         if (pick < 85) begin
            item.slot_id = '0;
         end
         if (pick >= 95) begin
            item.now = {$urandom, $urandom};
         end
      end
      if (wide_values && $urandom_range(0, 4) == 0) begin
         item.timestamp = {$urandom, $urandom};
         item.now       = {$urandom, $urandom};
      end
      return item;
   endfunction

   task automatic offer_item(input req_payload_type item);
      if ($urandom_range(0, 99) < gap_chance) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= item;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Called at the edge of the last transfer, so valid drops right there.
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic configure(input logic [STAMP_W-1:0] count_word,
                            input logic [STAMP_W-1:0] interval);
      logic [TCOUNT_W-1:0] count;
      count   = count_word[TCOUNT_W-1:0];
      hot_max = (count == 0) ? 0 : ((count > 64) ? 63 : int'(count) - 1);
      csr_we    <= 1'b1;
      csr_index <= CSR_THREAD_COUNT;
      csr_wdata <= count_word;
      @(posedge clock);
      csr_index <= CSR_REFRESH_INTERVAL;
      csr_wdata <= interval;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_random_traffic(input int count, input bit wide_values);
      for (int i = 0; i < count; i++) begin
         if (idling && i % 30 == 0) begin
            gap_chance   = ($urandom_range(0, 2) != 0) ? 25 : 0;
            stall_chance = ($urandom_range(0, 2) != 0) ? 12 : 0;
         end
         offer_item(next_random_item(wide_values));
      end
   endtask

   initial begin : stimulus
      logic [STAMP_W-1:0] count_word;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = CSR_THREAD_COUNT;
      csr_wdata      = '0;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      gap_chance   = 25;
      stall_chance = 12;

      // Directed opening under the reset settings (64 threads, interval 0).
      offer_item(item_of(KIND_RECORD, 6'd0,  64'd0, 64'd0));
      // No time has passed since the last refresh: the strict compare fails.
      offer_item(item_of(KIND_QUERY,  6'd0,  '0, 64'd0));
      // Refresh whose minimum is not larger leaves the watermark alone.
      offer_item(item_of(KIND_QUERY,  6'd0,  '0, 64'd5));
      offer_item(item_of(KIND_RECORD, 6'd0,  64'd100, 64'd6));
      offer_item(item_of(KIND_RECORD, 6'd0,  64'd50, 64'd7));
      offer_item(item_of(KIND_RECORD, 6'd0,  IDLE_STAMP, 64'd8));
      offer_item(item_of(KIND_RECORD, 6'd0,  IDLE_STAMP, 64'd9));
      offer_item(item_of(KIND_RECORD, 6'd63, 64'd40, 64'd10));
      offer_item(item_of(KIND_RECORD, 6'd1,  IDLE_STAMP - 64'd1, 64'd11));
      offer_item(item_of(KIND_RECORD, 6'd1,  64'd30, 64'd12));
      offer_item(item_of(KIND_QUERY,  6'd63, '0, IDLE_STAMP));
      offer_item(item_of(KIND_QUERY,  6'd0,  '0, 64'd20));
      offer_item(item_of(KIND_QUERY,  6'd0,  '0, 64'd20));
      offer_item(item_of(KIND_RECORD, 6'd42, 64'd25, 64'd21));
      // Time going backwards wraps to a huge elapsed value and refreshes.
      offer_item(item_of(KIND_QUERY,  6'd0,  '0, 64'd0));
      offer_item(item_of(KIND_RECORD, 6'd42, IDLE_STAMP, 64'd22));
      offer_item(item_of(KIND_RECORD, 6'd21, 64'd35, 64'd23));
      offer_item(item_of(KIND_RECORD, 6'd1,  64'd60, 64'd24));
      offer_item(item_of(KIND_QUERY,  6'd0,  '0, 64'd25));
      offer_item(item_of(KIND_RECORD, 6'd21, IDLE_STAMP, 64'd26));
      offer_item(item_of(KIND_RECORD, 6'd63, IDLE_STAMP, 64'd27));
      offer_item(item_of(KIND_RECORD, 6'd1,  IDLE_STAMP, 64'd28));
      wait_drained();

      configure(64'd64, 64'd0);
      run_random_traffic(RANDOM_ITEMS, 1'b0);
      wait_drained();

      configure(64'd1, 64'd50);
      run_random_traffic(RANDOM_ITEMS, 1'b0);
      wait_drained();

      // Thread count above the slot count, with junk above the register width.
      count_word                 = {$urandom, $urandom};
      count_word[TCOUNT_W-1:0]   = 7'd127;
      configure(count_word, 64'd200);
      run_random_traffic(RANDOM_ITEMS, 1'b0);
      wait_drained();

      configure(64'($urandom_range(2, 63)), 64'($urandom_range(0, 500)));
      run_random_traffic(RANDOM_ITEMS, 1'b0);
      wait_drained();

      // The largest interval can never be exceeded, so nothing refreshes.
      configure(64'd64, '1);
      run_random_traffic(RANDOM_ITEMS, 1'b0);
      wait_drained();

      idling       = 1'b0;
      gap_chance   = 0;
      stall_chance = 0;
      configure(64'd40, 64'd7);
      run_random_traffic(60, 1'b1);
      wait_drained();

      // With no slots scanned the minimum is all ones and the watermark jumps.
      configure(64'd0, 64'd0);
      offer_item(item_of(KIND_RECORD, 6'd3, 64'd100, wall_time));
      offer_item(item_of(KIND_QUERY,  6'd0, '0, wall_time + 64'd1));
      offer_item(item_of(KIND_QUERY,  6'd0, '0, wall_time + 64'd9));
      offer_item(item_of(KIND_QUERY,  6'd9, '0, wall_time + 64'd10));
      offer_item(item_of(KIND_RECORD, 6'd0, 64'd5, wall_time + 64'd11));
      wait_drained();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && outstanding == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
